// ===== design/dqt_pkg.sv =====
package dqt_pkg;

   localparam int DELIM_ENTRIES  = 8;
   localparam int PRES_ENTRIES   = 4;
   localparam int MAX_STRING_LEN = 4096;
   localparam int POS_W          = $clog2(MAX_STRING_LEN);
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_STRING_LEN - 1);

   localparam int CHAR_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CHAR_W-1:0] NUL_CHAR = '0;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_CHARS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_REPL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_FLAGS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_STARTS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_STOPS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_FLAGS  = 3'd5;

   typedef enum logic [1:0] {
      MODE_SKIP   = 2'd0,
      MODE_TOKEN  = 2'd1,
      MODE_REGION = 2'd2
   } mode_type;

   typedef struct packed {
      logic [63:0] delim_chars;
      logic [63:0] delim_repl;
      logic [15:0] delim_flags;
      logic [31:0] pres_starts;
      logic [31:0] pres_stops;
      logic [7:0]  pres_flags;
   } cfg_type;

   typedef struct packed {
      logic              delim_hit;
      logic              delim_replace;
      logic [CHAR_W-1:0] delim_repl_char;
      logic              pres_hit;
      logic [CHAR_W-1:0] pres_stop;
      logic              pres_strip;
   } match_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic [POS_W-1:0]  out_pos;
      logic              token_found;
      logic [POS_W-1:0]  token_pos;
      logic              end_of_string;
      logic              too_long;
   } rsp_type;

endpackage

// ===== design/delimiter_quote_tokenizer.sv =====
// Streaming tokenizer with quoted regions. One character enters per
// transfer on the req_ channel (0 ends the string) and exactly one result
// leaves per character on the rsp_ channel: the written-back character,
// its position, any token start found there, end of string and the
// saturation flag. The block takes a new character every cycle unless
// req_stall is high. A character passes the input register, then one
// pass of table compares and scan-state update into the result register,
// which raises rsp_valid; while the result register is full and stalled,
// the character waits in the input register.
// The per-character rate is set by the scan state loop, which updates once
// per character in that single pass. req_stall rises only while the input
// register holds a character and the result register is full and stalled.
// Configuration registers on the csr_ port are always ready and must be
// written only while no character is in flight.
module delimiter_quote_tokenizer
   import dqt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_in_char,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic [POS_W-1:0]      rsp_out_pos,
   output logic                  rsp_token_found,
   output logic [POS_W-1:0]      rsp_token_pos,
   output logic                  rsp_end_of_string,
   output logic                  rsp_too_long,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg;
   match_type         hit;
   rsp_type           rsp_next;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_free;
   logic              advance;
   logic              req_take;

   assign csr_ready = 1'b1;

   dqt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   dqt_match u_match (
      .cfg (cfg),
      .chr (in_char_ff),
      .hit (hit)
   );

   dqt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .chr     (in_char_ff),
      .hit     (hit),
      .rsp     (rsp_next)
   );

   // the result register can load when empty or when its result leaves now
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_in_char;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = rsp_next;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_char      = out_ff.out_char;
   assign rsp_out_pos       = out_ff.out_pos;
   assign rsp_token_found   = out_ff.token_found;
   assign rsp_token_pos     = out_ff.token_pos;
   assign rsp_end_of_string = out_ff.end_of_string;
   assign rsp_too_long      = out_ff.too_long;

   // a held character stays put while the result side is blocked
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_char_ff)))
      else $error("input register lost or changed a held character");

   // a saturated position always reads as the top position
   a_sat_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_long) |-> (rsp_out_pos == POS_TOP))
      else $error("too_long set without saturated position");

   // no token position without a token
   a_tpos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_token_found) |-> (rsp_token_pos == '0))
      else $error("token position nonzero without token");

   // a loaded result register always presents a result next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result register loaded but not valid");

endmodule

// ===== design/dqt_csr.sv =====
module dqt_csr
   import dqt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DELIM_CHARS: cfg_in.delim_chars = wr_data;
            CSR_DELIM_REPL:  cfg_in.delim_repl  = wr_data;
            CSR_DELIM_FLAGS: cfg_in.delim_flags = wr_data[15:0];
            CSR_PRES_STARTS: cfg_in.pres_starts = wr_data[31:0];
            CSR_PRES_STOPS:  cfg_in.pres_stops  = wr_data[31:0];
            CSR_PRES_FLAGS:  cfg_in.pres_flags  = wr_data[7:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/dqt_match.sv =====
module dqt_match
   import dqt_pkg::*;
(
   input  cfg_type           cfg,
   input  logic [CHAR_W-1:0] chr,
   output match_type         hit
);

   // scan from the top entry down so the lowest matching entry wins
   always_comb begin
      hit = '0;
      for (int i = DELIM_ENTRIES - 1; i >= 0; i--) begin
         if (cfg.delim_flags[i] && (cfg.delim_chars[8*i +: 8] != NUL_CHAR) &&
             (cfg.delim_chars[8*i +: 8] == chr)) begin
            hit.delim_hit       = 1'b1;
            hit.delim_replace   = cfg.delim_flags[8+i];
            hit.delim_repl_char = cfg.delim_repl[8*i +: 8];
         end
      end
      for (int j = PRES_ENTRIES - 1; j >= 0; j--) begin
         if (cfg.pres_flags[j] && (cfg.pres_starts[8*j +: 8] == chr)) begin
            hit.pres_hit   = 1'b1;
            hit.pres_stop  = cfg.pres_stops[8*j +: 8];
            hit.pres_strip = cfg.pres_flags[4+j];
         end
      end
   end

endmodule

// ===== design/dqt_core.sv =====
module dqt_core
   import dqt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [CHAR_W-1:0] chr,
   input  match_type         hit,
   output rsp_type           rsp
);

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CHAR_W-1:0] stop_ff, stop_in;
   logic              strip_ff, strip_in;
   logic [POS_W-1:0]  open_ff, open_in;
   logic              ovf_ff, ovf_in;

   logic              start_scan;
   logic              eos;

   always_comb begin
      mode_in  = mode_ff;
      stop_in  = stop_ff;
      strip_in = strip_ff;
      open_in  = open_ff;
      start_scan = 1'b0;
      eos = (chr == NUL_CHAR);

      rsp = '0;
      rsp.out_char      = chr;
      rsp.out_pos       = pos_ff;
      rsp.too_long      = ovf_ff;
      rsp.end_of_string = eos;

      if (eos) begin
         if ((mode_ff == MODE_REGION) && strip_ff) begin
            rsp.token_found = 1'b1;
            rsp.token_pos   = open_ff;
         end
      end else begin
         case (mode_ff)
            MODE_TOKEN: begin
               if (hit.delim_hit) begin
                  if (hit.delim_replace) begin
                     rsp.out_char = hit.delim_repl_char;
                  end
                  mode_in = MODE_SKIP;
               end else if (hit.pres_hit) begin
                  start_scan = 1'b1;
               end
            end
            MODE_REGION: begin
               if (chr == stop_ff) begin
                  if (strip_ff) begin
                     rsp.out_char    = NUL_CHAR;
                     rsp.token_found = 1'b1;
                     rsp.token_pos   = (open_ff == POS_TOP) ? POS_TOP : open_ff + 1'b1;
                     mode_in = MODE_SKIP;
                  end else begin
                     start_scan = 1'b1;
                  end
               end
            end
            default: start_scan = 1'b1;
         endcase
      end

      if (start_scan) begin
         if (hit.delim_hit) begin
            mode_in = MODE_SKIP;
         end else if (hit.pres_hit) begin
            mode_in  = MODE_REGION;
            stop_in  = hit.pres_stop;
            strip_in = hit.pres_strip;
            open_in  = pos_ff;
            if (!hit.pres_strip) begin
               rsp.token_found = 1'b1;
               rsp.token_pos   = pos_ff;
            end
         end else begin
            mode_in = MODE_TOKEN;
            rsp.token_found = 1'b1;
            rsp.token_pos   = pos_ff;
         end
      end

      // position counter saturates at the top value
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (eos) begin
         mode_in  = MODE_SKIP;
         pos_in   = '0;
         stop_in  = NUL_CHAR;
         strip_in = 1'b0;
         open_in  = '0;
         ovf_in   = 1'b0;
      end else if (pos_ff == POS_TOP) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SKIP;
         pos_ff   <= '0;
         stop_ff  <= NUL_CHAR;
         strip_ff <= 1'b0;
         open_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
         strip_ff <= strip_in;
         open_ff  <= open_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== tb/sv/dqt_checker.sv =====
`timescale 1ns / 100ps

module dqt_result_checker
   import dqt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_in_char,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CHAR_W-1:0]     rsp_out_char,
   input  logic [POS_W-1:0]      rsp_out_pos,
   input  logic                  rsp_token_found,
   input  logic [POS_W-1:0]      rsp_token_pos,
   input  logic                  rsp_end_of_string,
   input  logic                  rsp_too_long,

   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   output int                    fail_count,
   output int                    results_in_flight,
   output int                    results_checked,
   output int                    tokens_seen,
   output int                    strings_seen,
   output int                    saturated_seen
);

   // shadow copy of the tables and the scan state
   cfg_type           tbl;
   mode_type          scan_mode;
   logic [POS_W-1:0]  next_pos;
   logic [CHAR_W-1:0] stop_char;
   logic              strip_on;
   logic [POS_W-1:0]  open_pos;
   logic              saturated;

   rsp_type token_results_q [$];

   function automatic void clear_scan();
      scan_mode = MODE_SKIP;
      next_pos  = '0;
      stop_char = NUL_CHAR;
      strip_on  = 1'b0;
      open_pos  = '0;
      saturated = 1'b0;
   endfunction

   function automatic int delim_entry(input logic [CHAR_W-1:0] c);
      int i;
      for (i = 0; i < DELIM_ENTRIES; i++) begin
         if (tbl.delim_flags[i] && tbl.delim_chars[8*i +: 8] != NUL_CHAR &&
             tbl.delim_chars[8*i +: 8] == c)
            return i;
      end
      return -1;
   endfunction

   function automatic int pres_entry(input logic [CHAR_W-1:0] c);
      int i;
      for (i = 0; i < PRES_ENTRIES; i++) begin
         if (tbl.pres_flags[i] && tbl.pres_starts[8*i +: 8] == c)
            return i;
      end
      return -1;
   endfunction

   // examine a character as the start of a new scan
   function automatic void open_scan(input logic [CHAR_W-1:0] c,
                                     input logic [POS_W-1:0] pos,
                                     inout logic found,
                                     inout logic [POS_W-1:0] tpos);
      int p;
      if (delim_entry(c) >= 0) begin
         scan_mode = MODE_SKIP;
         return;
      end
      p = pres_entry(c);
      if (p >= 0) begin
         scan_mode = MODE_REGION;
         stop_char = tbl.pres_stops[8*p +: 8];
         strip_on  = tbl.pres_flags[4+p];
         open_pos  = pos;
         if (!strip_on) begin
            found = 1'b1;
            tpos  = pos;
         end
         return;
      end
      scan_mode = MODE_TOKEN;
      found     = 1'b1;
      tpos      = pos;
   endfunction

   function automatic rsp_type tokenize_char(input logic [CHAR_W-1:0] c);
      rsp_type           r;
      int                d;
      logic              found;
      logic [POS_W-1:0]  tpos;
      logic [CHAR_W-1:0] oc;
      logic              eos;
      found       = 1'b0;
      tpos        = '0;
      oc          = c;
      eos         = 1'b0;
      r.out_pos   = next_pos;
      r.too_long  = saturated;
      if (c == NUL_CHAR) begin
         eos = 1'b1;
         if (scan_mode == MODE_REGION && strip_on) begin
            found = 1'b1;
            tpos  = open_pos;
         end
      end else if (scan_mode == MODE_TOKEN) begin
         d = delim_entry(c);
         if (d >= 0) begin
            if (tbl.delim_flags[8+d])
               oc = tbl.delim_repl[8*d +: 8];
            scan_mode = MODE_SKIP;
         end else if (pres_entry(c) >= 0) begin
            open_scan(c, next_pos, found, tpos);
         end
      end else if (scan_mode == MODE_REGION) begin
         if (c == stop_char) begin
            if (strip_on) begin
               oc        = NUL_CHAR;
               found     = 1'b1;
               tpos      = (open_pos < POS_TOP) ? open_pos + 1'b1 : POS_TOP;
               scan_mode = MODE_SKIP;
            end else begin
               open_scan(c, next_pos, found, tpos);
            end
         end
      end else begin
         open_scan(c, next_pos, found, tpos);
      end

      if (eos) begin
         clear_scan();
      end else if (next_pos >= POS_TOP) begin
         next_pos  = POS_TOP;
         saturated = 1'b1;
      end else begin
         next_pos = next_pos + 1'b1;
      end

      r.out_char      = oc;
      r.token_found   = found;
      r.token_pos     = found ? tpos : '0;
      r.end_of_string = eos;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      if (fail_count < 50)
         $display("mismatch on result %0d: %s expected %h got %h",
                  results_checked, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         tbl = '0;
         clear_scan();
         token_results_q.delete();
         fail_count        = 0;
         results_in_flight = 0;
         results_checked   = 0;
         tokens_seen       = 0;
         strings_seen      = 0;
         saturated_seen    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.out_char      = rsp_out_char;
            got.out_pos       = rsp_out_pos;
            got.token_found   = rsp_token_found;
            got.token_pos     = rsp_token_pos;
            got.end_of_string = rsp_end_of_string;
            got.too_long      = rsp_too_long;
            if (token_results_q.size() == 0) begin
               report_mismatch("result with nothing outstanding, out_char", '0,
                               got.out_char);
            end else begin
               want = token_results_q.pop_front();
               if (got.out_char !== want.out_char)
                  report_mismatch("out_char", want.out_char, got.out_char);
               if (got.out_pos !== want.out_pos)
                  report_mismatch("out_pos", want.out_pos, got.out_pos);
               if (got.token_found !== want.token_found)
                  report_mismatch("token_found", want.token_found, got.token_found);
               if (got.token_pos !== want.token_pos)
                  report_mismatch("token_pos", want.token_pos, got.token_pos);
               if (got.end_of_string !== want.end_of_string)
                  report_mismatch("end_of_string", want.end_of_string,
                                  got.end_of_string);
               if (got.too_long !== want.too_long)
                  report_mismatch("too_long", want.too_long, got.too_long);
            end
            results_checked++;
            if (got.token_found === 1'b1)   tokens_seen++;
            if (got.end_of_string === 1'b1) strings_seen++;
            if (got.too_long === 1'b1)      saturated_seen++;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DELIM_CHARS: tbl.delim_chars = csr_wdata;
               CSR_DELIM_REPL:  tbl.delim_repl  = csr_wdata;
               CSR_DELIM_FLAGS: tbl.delim_flags = csr_wdata[15:0];
               CSR_PRES_STARTS: tbl.pres_starts = csr_wdata[31:0];
               CSR_PRES_STOPS:  tbl.pres_stops  = csr_wdata[31:0];
               CSR_PRES_FLAGS:  tbl.pres_flags  = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall)
            token_results_q.push_back(tokenize_char(req_in_char));

         results_in_flight = token_results_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_delimiter_quote_tokenizer.sv =====
`timescale 1ns / 100ps

module tb_delimiter_quote_tokenizer
   import dqt_pkg::*;
();

   // Spare register indexes: the block must ignore writes to them.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;      // two-stage pipe, with margin
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off

   logic                  clock;
   logic                  reset;

   logic                  req_valid;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_in_char;

   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CHAR_W-1:0]     rsp_out_char;
   logic [POS_W-1:0]      rsp_out_pos;
   logic                  rsp_token_found;
   logic [POS_W-1:0]      rsp_token_pos;
   logic                  rsp_end_of_string;
   logic                  rsp_too_long;

   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int results_in_flight;
   int results_checked;
   int tokens_seen;
   int strings_seen;
   int saturated_seen;

   int      cycle_count;
   int      sent_items;
   int      burst_left;
   int      table_loads;
   bit      hold_request;
   cfg_type cur_tables;

   delimiter_quote_tokenizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_char       (req_in_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_out_pos       (rsp_out_pos),
      .rsp_token_found   (rsp_token_found),
      .rsp_token_pos     (rsp_token_pos),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_too_long      (rsp_too_long),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   dqt_result_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_char       (req_in_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_out_pos       (rsp_out_pos),
      .rsp_token_found   (rsp_token_found),
      .rsp_token_pos     (rsp_token_pos),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_too_long      (rsp_too_long),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .results_in_flight (results_in_flight),
      .results_checked   (results_checked),
      .tokens_seen       (tokens_seen),
      .strings_seen      (strings_seen),
      .saturated_seen    (saturated_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort the run if the block hangs or an expectation never arrives.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped at the cycle limit with %0d results outstanding",
               results_in_flight);
      $display("status: fail");
      $finish;
   end

   // Receiver: pick a stall density for a random span of cycles, from none
   // to heavy. When asked, hold off for a long stretch so the pipe fills
   // and the block pushes back on its input.
   initial begin : receiver
      int stall_pct;
      int span;
      int hold_count;
      rsp_stall <= 1'b0;
      forever begin
         case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 80;
         endcase
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(posedge clock);
            if (hold_request) begin
               hold_request = 1'b0;
               hold_count   = 0;
               rsp_stall   <= 1'b1;
               while (hold_count < HOLD_CYCLES) begin
                  @(posedge clock);
                  hold_count++;
               end
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Offer one character and hold it until the block takes it. Between
   // bursts, drop valid for a random gap; within a burst, keep valid high
   // so the next call simply replaces the payload.
   task automatic send_char(input logic [CHAR_W-1:0] c);
      int gap;
      req_valid   <= 1'b1;
      req_in_char <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
      if (burst_left == 0) begin
         burst_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
         gap          = $urandom_range(1, 6);
         req_valid   <= 1'b0;
         req_in_char <= CHAR_W'($urandom);
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Drop valid and wait until every predicted result has come back, then
   // let the pipe go quiet before touching the tables.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Put one register write on the csr_ port. Lower valid again before returning
   // so valid is never lowered and raised in the same step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_tables(input cfg_type t);
      cur_tables = t;
      write_csr(CSR_DELIM_CHARS, t.delim_chars);
      write_csr(CSR_DELIM_REPL,  t.delim_repl);
      write_csr(CSR_DELIM_FLAGS, CSR_DATA_W'(t.delim_flags));
      write_csr(CSR_PRES_STARTS, CSR_DATA_W'(t.pres_starts));
      write_csr(CSR_PRES_STOPS,  CSR_DATA_W'(t.pres_stops));
      write_csr(CSR_PRES_FLAGS,  CSR_DATA_W'(t.pres_flags));
      table_loads++;
   endtask

   // Table characters come from a small punctuation range so that string
   // characters hit them often; now and then an entry holds zero.
   function automatic logic [CHAR_W-1:0] table_char();
      if ($urandom_range(0, 7) == 0)
         return NUL_CHAR;
      return CHAR_W'(8'h20 + $urandom_range(0, 15));
   endfunction

   function automatic cfg_type random_tables();
      cfg_type t;
      int      i;
      for (i = 0; i < DELIM_ENTRIES; i++) begin
         t.delim_chars[8*i +: 8] = table_char();
         t.delim_repl[8*i +: 8]  = CHAR_W'($urandom);
      end
      t.delim_flags = 16'($urandom);
      for (i = 0; i < PRES_ENTRIES; i++) begin
         t.pres_starts[8*i +: 8] = table_char();
         t.pres_stops[8*i +: 8]  = table_char();
      end
      t.pres_flags = 8'($urandom);
      return t;
   endfunction

   // Nonzero filler: mostly letters, often table punctuation, rarely any byte.
   function automatic logic [CHAR_W-1:0] filler_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return CHAR_W'(8'h61 + $urandom_range(0, 7));
      if (r < 92)
         return CHAR_W'(8'h20 + $urandom_range(0, 15));
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   // One string built from segments: words, delimiters taken from the
   // current table, quoted regions (sometimes left open), and noise bytes.
   task automatic send_string();
      int                segs;
      int                k;
      int                e;
      logic [CHAR_W-1:0] open_ch;
      logic [CHAR_W-1:0] close_ch;
      logic [CHAR_W-1:0] d_ch;
      segs = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      for (k = 0; k < segs; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               repeat ($urandom_range(1, 5)) send_char(filler_char());
            end
            3, 4, 5: begin
               e    = $urandom_range(0, DELIM_ENTRIES - 1);
               d_ch = cur_tables.delim_chars[8*e +: 8];
               send_char((d_ch == NUL_CHAR) ? filler_char() : d_ch);
            end
            6, 7, 8: begin
               e        = $urandom_range(0, PRES_ENTRIES - 1);
               open_ch  = cur_tables.pres_starts[8*e +: 8];
               close_ch = cur_tables.pres_stops[8*e +: 8];
               if (open_ch != NUL_CHAR) send_char(open_ch);
               repeat ($urandom_range(0, 4)) send_char(filler_char());
               if (close_ch != NUL_CHAR && $urandom_range(0, 5) != 0)
                  send_char(close_ch);
            end
            default: begin
               send_char(CHAR_W'($urandom_range(1, 255)));
            end
         endcase
      end
      send_char(NUL_CHAR);
   endtask

   task automatic random_phase(input int budget);
      int start;
      start = sent_items;
      while (sent_items - start < budget) send_string();
   endtask

   // Run one string past the last position: quoted regions open just before
   // and after saturation, two closed, one left open at the end.
   task automatic send_long_string();
      logic [CHAR_W-1:0] tail [10];
      int                i;
      tail = '{CH_QUOTE, 8'h78, CH_QUOTE, 8'h71, CH_QUOTE,
               8'h7A, CH_QUOTE, 8'h77, CH_QUOTE, NUL_CHAR};
      for (i = 0; i < int'(POS_TOP) - 1; i++)
         send_char((i % 9 == 8) ? CH_SPACE : CHAR_W'(8'h61 + i % 5));
      foreach (tail[j]) send_char(tail[j]);
   endtask

   initial begin : stimulus
      cfg_type           tables_a;
      cfg_type           tables_x;
      logic [CHAR_W-1:0] directed [27];
      int                k;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_char <= NUL_CHAR;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_DELIM_CHARS;
      csr_wdata   <= '0;
      sent_items   = 0;
      burst_left   = 0;
      table_loads  = 0;
      hold_request = 1'b0;
      cur_tables   = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Tables at reset: nothing matches, every string is one token.
      send_char(8'h41);
      send_char(CH_SPACE);
      send_char(8'hFF);
      send_char(NUL_CHAR);
      settle();

      // Hand-built tables:
      //   delimiters ' ' ',' zero(valid) ';' '(' ',' 0xFF tab(invalid)
      //   the second ',' loses to the first; ',' 0xFF and entry 5 replace
      //   regions: '"' strip to '"', '[' to ',', '{' to '"', '(' strip to ')'
      //   '(' is also a delimiter, so it never opens a region
      tables_a.delim_chars = {8'h09, 8'hFF, 8'h2C, 8'h28, 8'h3B, 8'h00, 8'h2C, 8'h20};
      tables_a.delim_repl  = {8'h2A, 8'h5F, 8'h23, 8'h2A, 8'h2A, 8'h2A, 8'h7C, 8'h2A};
      tables_a.delim_flags = 16'h627F;
      tables_a.pres_starts = {8'h28, 8'h7B, 8'h5B, 8'h22};
      tables_a.pres_stops  = {8'h29, 8'h22, 8'h2C, 8'h22};
      tables_a.pres_flags  = 8'h9F;
      load_tables(tables_a);

      // leading delimiter, replaced delimiter, stripped region, region opened
      // inside a token, stop that is a delimiter, stop that opens a new
      // region, delimiter-and-start char, extremes, unterminated regions
      directed = '{8'h20, 8'h61, 8'h2C, 8'h3B, 8'h22, 8'h78, 8'h20, 8'h22, 8'h63,
                   8'h5B, 8'h79, 8'h2C, 8'h7B, 8'h7A, 8'h22, 8'h22, 8'h28, 8'h6B,
                   8'hFF, 8'h01, NUL_CHAR, 8'h22, 8'h75, NUL_CHAR, 8'h5B, 8'h76,
                   NUL_CHAR};
      foreach (directed[j]) send_char(directed[j]);
      settle();

      // All ones: every entry valid and 0xFF everywhere.
      load_tables('1);
      random_phase(200);
      settle();

      // All zeros written back, plus writes to the spare indexes.
      load_tables('0);
      write_csr(CSR_SPARE_LO, {$urandom, $urandom});
      write_csr(CSR_SPARE_HI, {$urandom, $urandom});
      random_phase(150);
      settle();

      load_tables(tables_a);
      send_long_string();
      settle();

      // Random tables; on the second set, stall the receiver for a long run.
      for (k = 0; k < 5; k++) begin
         tables_x = random_tables();
         load_tables(tables_x);
         if (k == 1)
            hold_request = 1'b1;
         random_phase(290);
         settle();
      end

      $display("checked %0d results: %0d token starts, %0d strings, %0d saturated",
               results_checked, tokens_seen, strings_seen, saturated_seen);
      $display("%0d table loads incl. all-zero and all-one tables, one long hold-off",
               table_loads);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
